// ===== rtl/fts_pkg.sv =====
// ----------------------------------------------------------------------------
// fts_pkg
// Shared widths, register indexes and reset values of the frame time smoother.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int DUR_W      = 32;  // signed frame duration
    localparam int TIME_W     = 48;  // time ports
    localparam int FRAME_W    = 32;  // frame counter
    localparam int WIN_W      = 7;
    localparam int DEF_W      = 18;
    localparam int SPIKE_W    = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN  = 3'd3;

    localparam logic [WIN_W-1:0]   WIN_RESET   = 7'd10;
    localparam logic [DEF_W-1:0]   DEF_RESET   = 18'd16667;
    localparam logic [SPIKE_W-1:0] SPIKE_RESET = 31'd200000;

endpackage

// ===== rtl/fts_hist.sv =====
// ----------------------------------------------------------------------------
// fts_hist
// Duration history ring: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fts_hist #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_waddr,
    input  logic [fts_pkg::DUR_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]         i_raddr,
    output logic [fts_pkg::DUR_W-1:0] o_rdata
);
    import fts_pkg::*;

    logic [DUR_W-1:0] r_mem [DEPTH];
    logic [DUR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fts_div.sv =====
// ----------------------------------------------------------------------------
// fts_div
// Radix-2 restoring divider: signed window sum by unsigned entry count,
// one quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module fts_div #(
    parameter int SUM_W = 38,
    parameter int CNT_W = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [SUM_W-1:0]   i_dividend,
    input  logic [CNT_W-1:0]          i_divisor,
    output logic                      o_done,
    output logic [fts_pkg::DUR_W-1:0] o_quot
);
    import fts_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_quo;
    logic              r_neg;

    logic [CNT_W:0]    w_sh;
    logic [CNT_W:0]    w_sub;
    logic              w_ge;
    logic [SUM_W-1:0]  w_mag;
    logic [SUM_W-1:0]  w_qs;

    assign w_sh  = {r_rem, r_quo[SUM_W-1]};
    assign w_ge  = w_sh >= {1'b0, r_div};
    assign w_sub = w_sh - {1'b0, r_div};
    assign w_mag = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
    assign w_qs  = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_step == STEP_W'(SUM_W - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_step <= '0;
            r_rem  <= '0;
            r_quo  <= w_mag;
            r_neg  <= i_dividend[SUM_W-1];
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_step <= r_step + STEP_W'(1);
            r_rem  <= w_ge ? w_sub[CNT_W-1:0] : w_sh[CNT_W-1:0];
            r_quo  <= {r_quo[SUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = w_qs[DUR_W-1:0];

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

endmodule

// ===== rtl/frame_time_smoother.sv =====
// ----------------------------------------------------------------------------
// frame_time_smoother
// Frame duration smoother: spike-rejecting moving average of tick intervals.
// ----------------------------------------------------------------------------
// Each input transaction is one frame tick with a microsecond time reading.
// The block forms the saturated duration since the previous reading, swaps
// durations above spike_limit for the newest history entry, updates the
// history window and its running sum, divides the sum by the entry count and
// adds the result to the elapsed time. The bit-serial divider produces one
// quotient bit per cycle over the 32 + log2(MAX_WINDOW) bit window sum. The
// input is stalled while a tick is in progress or a configuration write is
// offered; a finished result waits in the output register while the next
// tick is accepted, and an output stall that outlasts the next tick holds
// that tick in its last state. Configuration writes are taken only while
// idle; those to indexes up to CFG_ORIGIN clear the history to the single
// default entry.
// ----------------------------------------------------------------------------
module frame_time_smoother #(
    parameter int MAX_WINDOW = 64,
    parameter int TIME_BITS  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [fts_pkg::TIME_W-1:0]     i_source_time,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [fts_pkg::DUR_W-1:0]      o_measured_duration,
    output logic [fts_pkg::DUR_W-1:0]      o_predicted_duration,
    output logic [fts_pkg::TIME_W-1:0]     o_elapsed_time,
    output logic [fts_pkg::FRAME_W-1:0]    o_frame_count,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fts_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fts_pkg::*;

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = DUR_W + IDX_W;
    localparam int EXT_W = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
    localparam logic signed [TIME_BITS:0] L_DMAX = (TIME_BITS+1)'(64'sd2147483647);
    localparam logic signed [TIME_BITS:0] L_DMIN = (TIME_BITS+1)'(-64'sd2147483648);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MEAS   = 7'b0000010,
        S_DROP   = 7'b0000100,
        S_ADD    = 7'b0001000,
        S_DSTART = 7'b0010000,
        S_DWAIT  = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic [WIN_W-1:0]        r_window, n_window;
    logic [DEF_W-1:0]        r_default, n_default;
    logic [SPIKE_W-1:0]      r_spike, n_spike;
    logic [TIME_BITS-1:0]    r_origin, n_origin;
    logic [TIME_BITS-1:0]    r_last, n_last;
    logic [TIME_BITS-1:0]    r_now, n_now;
    logic [IDX_W-1:0]        r_head, n_head;
    logic [CNT_W-1:0]        r_count, n_count;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [DUR_W-1:0]        r_newest, n_newest;
    logic [TIME_BITS-1:0]    r_total, n_total;
    logic [FRAME_W-1:0]      r_tick, n_tick;
    logic [DUR_W-1:0]        r_dur, n_dur;
    logic [DUR_W-1:0]        r_pred, n_pred;
    logic                    r_def0, n_def0;
    logic                    r_use_def, n_use_def;
    logic                    r_out_valid, n_out_valid;
    logic [DUR_W-1:0]        r_o_meas, n_o_meas;
    logic [DUR_W-1:0]        r_o_pred, n_o_pred;
    logic [TIME_W-1:0]       r_o_elapsed, n_o_elapsed;
    logic [FRAME_W-1:0]      r_o_frame, n_o_frame;

    logic                    w_cfg_acc, w_cfg_ok, w_in_acc;
    logic [EXT_W-1:0]        w_src_ext, w_org_ext, w_tot_ext;
    logic [TIME_BITS-1:0]    w_src, w_org_new;
    logic [DEF_W-1:0]        w_def_new;
    logic [CNT_W-1:0]        w_win;
    logic [CNT_W:0]          w_old_raw, w_old_wrap;
    logic [IDX_W-1:0]        w_old_idx, w_head_inc;
    logic signed [TIME_BITS:0] w_diff;
    logic [DUR_W-1:0]        w_sat;
    logic [DUR_W-1:0]        w_rdata, w_opnd;
    logic signed [SUM_W-1:0] w_sum_res;
    logic                    w_mem_we;
    logic                    w_div_done;
    logic [DUR_W-1:0]        w_quot;
    logic [TIME_BITS-1:0]    w_total_new;
    logic [FRAME_W-1:0]      w_tick_new;

    assign w_cfg_acc = i_cfg_valid && o_cfg_ready;
    assign w_cfg_ok  = i_cfg_index <= CFG_ORIGIN;
    assign w_in_acc  = i_in_valid && !o_in_stall;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;

    assign w_src_ext = EXT_W'(i_source_time);
    assign w_src     = w_src_ext[TIME_BITS-1:0];
    assign w_org_ext = EXT_W'(i_cfg_data[TIME_W-1:0]);
    assign w_org_new = (i_cfg_index == CFG_ORIGIN) ? w_org_ext[TIME_BITS-1:0] : r_origin;
    assign w_def_new = (i_cfg_index == CFG_DEFAULT) ? i_cfg_data[DEF_W-1:0] : r_default;
    assign w_tot_ext = EXT_W'(w_total_new);

    // effective window: 1..MAX_WINDOW
    always_comb begin
        if (r_window == '0) begin
            w_win = CNT_W'(1);
        end else if (int'(r_window) > MAX_WINDOW) begin
            w_win = CNT_W'(MAX_WINDOW);
        end else begin
            w_win = CNT_W'(r_window);
        end
    end

    // oldest slot = head + 1 - count, modulo MAX_WINDOW
    assign w_old_raw  = (CNT_W+1)'(r_head) + (CNT_W+1)'(MAX_WINDOW + 1) - (CNT_W+1)'(r_count);
    assign w_old_wrap = (w_old_raw >= (CNT_W+1)'(MAX_WINDOW)) ?
                        (w_old_raw - (CNT_W+1)'(MAX_WINDOW)) : w_old_raw;
    assign w_old_idx  = w_old_wrap[IDX_W-1:0];
    assign w_head_inc = (r_head == IDX_W'(MAX_WINDOW - 1)) ? '0 : (r_head + IDX_W'(1));

    assign w_diff = $signed({1'b0, r_now}) - $signed({1'b0, r_last});
    always_comb begin
        if (w_diff > L_DMAX) begin
            w_sat = 32'h7FFF_FFFF;
        end else if (w_diff < L_DMIN) begin
            w_sat = 32'h8000_0000;
        end else begin
            w_sat = w_diff[DUR_W-1:0];
        end
    end

    // shared sum adder: subtract the oldest entry if full, then add the new one
    assign w_opnd    = (r_state == S_DROP) ?
                       (r_use_def ? DUR_W'(r_default) : w_rdata) : r_dur;
    assign w_sum_res = (r_state == S_DROP) ? (r_sum - SUM_W'($signed(w_opnd)))
                                           : (r_sum + SUM_W'($signed(w_opnd)));

    assign w_total_new = r_total + TIME_BITS'($signed(r_pred));
    assign w_tick_new  = r_tick + FRAME_W'(1);

    assign w_mem_we = (r_state == S_ADD);

    fts_hist #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (IDX_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_head_inc),
        .i_wdata (r_dur),
        .i_raddr (w_old_idx),
        .o_rdata (w_rdata)
    );

    fts_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_window    = r_window;
        n_default   = r_default;
        n_spike     = r_spike;
        n_origin    = r_origin;
        n_last      = r_last;
        n_now       = r_now;
        n_head      = r_head;
        n_count     = r_count;
        n_sum       = r_sum;
        n_newest    = r_newest;
        n_total     = r_total;
        n_tick      = r_tick;
        n_dur       = r_dur;
        n_pred      = r_pred;
        n_def0      = r_def0;
        n_use_def   = r_use_def;
        n_out_valid = r_out_valid;
        n_o_meas    = r_o_meas;
        n_o_pred    = r_o_pred;
        n_o_elapsed = r_o_elapsed;
        n_o_frame   = r_o_frame;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                priority if (w_cfg_acc && w_cfg_ok) begin
                    unique case (i_cfg_index)
                        CFG_WINDOW:  n_window = i_cfg_data[WIN_W-1:0];
                        CFG_SPIKE:   n_spike  = i_cfg_data[SPIKE_W-1:0];
                        default:     ;
                    endcase
                    n_default = w_def_new;
                    n_origin  = w_org_new;
                    n_head    = '0;
                    n_count   = CNT_W'(1);
                    n_sum     = SUM_W'(w_def_new);
                    n_newest  = DUR_W'(w_def_new);
                    n_last    = w_org_new;
                    n_def0    = 1'b1;
                end else if (w_in_acc) begin
                    n_now   = w_src;
                    n_state = S_MEAS;
                end else begin
                end
            end
            S_MEAS: begin
                n_dur     = ($signed(w_sat) > $signed({1'b0, r_spike})) ? r_newest : w_sat;
                n_last    = r_now;
                n_use_def = (w_old_idx == '0) && r_def0;
                n_state   = S_DROP;
            end
            S_DROP: begin
                if (r_count >= w_win) begin
                    n_sum   = w_sum_res;
                    n_count = r_count - CNT_W'(1);
                end
                n_state = S_ADD;
            end
            S_ADD: begin
                n_head   = w_head_inc;
                n_newest = r_dur;
                n_sum    = w_sum_res;
                n_count  = r_count + CNT_W'(1);
                if (w_head_inc == '0) begin
                    n_def0 = 1'b0;
                end
                n_state  = S_DSTART;
            end
            S_DSTART: begin
                n_state = S_DWAIT;
            end
            S_DWAIT: begin
                if (w_div_done) begin
                    n_pred  = w_quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_total     = w_total_new;
                    n_tick      = w_tick_new;
                    n_o_meas    = r_dur;
                    n_o_pred    = r_pred;
                    n_o_elapsed = w_tot_ext[TIME_W-1:0];
                    n_o_frame   = w_tick_new;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WIN_RESET;
            r_default   <= DEF_RESET;
            r_spike     <= SPIKE_RESET;
            r_origin    <= '0;
            r_last      <= '0;
            r_head      <= '0;
            r_count     <= CNT_W'(1);
            r_sum       <= SUM_W'(DEF_RESET);
            r_newest    <= DUR_W'(DEF_RESET);
            r_total     <= '0;
            r_tick      <= '0;
            r_def0      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_window    <= n_window;
            r_default   <= n_default;
            r_spike     <= n_spike;
            r_origin    <= n_origin;
            r_last      <= n_last;
            r_head      <= n_head;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_newest    <= n_newest;
            r_total     <= n_total;
            r_tick      <= n_tick;
            r_def0      <= n_def0;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now       <= n_now;
        r_dur       <= n_dur;
        r_pred      <= n_pred;
        r_use_def   <= n_use_def;
        r_o_meas    <= n_o_meas;
        r_o_pred    <= n_o_pred;
        r_o_elapsed <= n_o_elapsed;
        r_o_frame   <= n_o_frame;
    end

    assign o_out_valid          = r_out_valid;
    assign o_measured_duration  = r_o_meas;
    assign o_predicted_duration = r_o_pred;
    assign o_elapsed_time       = r_o_elapsed;
    assign o_frame_count        = r_o_frame;

    a_count_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count != '0 && r_count <= w_win))
        else $error("history entry count outside window");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside output state");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_acc && w_cfg_ok) |=> (r_count == CNT_W'(1) && r_head == '0 && r_def0))
        else $error("config transaction did not clear history");

endmodule

// ===== test/frame_time_smoother_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_time_smoother_tb
// Self-checking bench for the spike-rejecting frame duration smoother.
// ----------------------------------------------------------------------------
// Frame ticks are queued by the sequencer and fed by a clocked driver; every
// accepted tick runs through a local model of the smoothing window, and the
// monitor checks each output transaction against the oldest predicted frame.
// Directed ticks cover saturation, spikes, backward readings and window
// clamping; random phases reprogram all registers and mix regular frame
// cadence with spikes, jumps and noise, under random valid and stall gaps.
// ----------------------------------------------------------------------------
module frame_time_smoother_tb;
    import fts_pkg::*;

    localparam int RING_DEPTH      = 64;
    localparam int IDLE_PCT        = 38;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SETTLE_CYCLES   = 60;
    localparam int RANDOM_PHASES   = 12;
    localparam int TICKS_PER_PHASE = 167;
    localparam int REPORT_LIMIT    = 10;

    localparam logic [TIME_W-1:0]       TIME_MAX = '1;
    localparam logic [TIME_W-1:0]       SAT_SPAN = 48'h0000_7FFF_FFFF;
    localparam logic signed [DUR_W-1:0] DUR_HI   = 32'sh7FFF_FFFF;
    localparam logic signed [DUR_W-1:0] DUR_LO   = 32'sh8000_0000;

    typedef struct packed {
        logic [DUR_W-1:0]   measured;
        logic [DUR_W-1:0]   predicted;
        logic [TIME_W-1:0]  elapsed;
        logic [FRAME_W-1:0] frames;
    } t_frame_result;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic [TIME_W-1:0]     i_source_time = '0;
    logic                  i_out_stall   = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = CFG_WINDOW;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [DUR_W-1:0]      o_measured_duration;
    logic [DUR_W-1:0]      o_predicted_duration;
    logic [TIME_W-1:0]     o_elapsed_time;
    logic [FRAME_W-1:0]    o_frame_count;
    logic                  o_cfg_ready;

    frame_time_smoother i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // model state
    logic [WIN_W-1:0]        win_reg;
    logic [DEF_W-1:0]        def_reg;
    logic [SPIKE_W-1:0]      spike_reg;
    logic [TIME_W-1:0]       origin_reg;
    logic [TIME_W-1:0]       prev_time;
    logic signed [DUR_W-1:0] ring [RING_DEPTH];
    int unsigned             head;
    int unsigned             fill;
    longint                  window_sum;
    logic signed [DUR_W-1:0] newest;
    logic [TIME_W-1:0]       elapsed_acc;
    logic [FRAME_W-1:0]      frame_acc;

    logic [TIME_W-1:0] source_times [$];
    t_frame_result     expected_frames [$];
    logic [TIME_W-1:0] t_cur;
    bit                calm = 1'b0;
    int unsigned       mismatches = 0;
    int unsigned       idle_cycles = 0;

    function automatic void clear_window();
        head       = 0;
        fill       = 1;
        ring[0]    = DUR_W'(def_reg);
        newest     = DUR_W'(def_reg);
        window_sum = longint'(def_reg);
        prev_time  = origin_reg;
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_WINDOW:  win_reg    = data[WIN_W-1:0];
            CFG_DEFAULT: def_reg    = data[DEF_W-1:0];
            CFG_SPIKE:   spike_reg  = data[SPIKE_W-1:0];
            CFG_ORIGIN:  origin_reg = data[TIME_W-1:0];
            default:     return;
        endcase
        clear_window();
    endfunction

    function automatic logic signed [DUR_W-1:0] tick_duration(logic [TIME_W-1:0] now,
                                                              logic [TIME_W-1:0] prev);
        logic [TIME_W-1:0] d;
        if (now >= prev) begin
            d = now - prev;
            return (d > SAT_SPAN) ? DUR_HI : DUR_W'(d);
        end
        d = prev - now;
        return (d > SAT_SPAN) ? DUR_LO : -$signed(DUR_W'(d));
    endfunction

    function automatic t_frame_result smoother_step(logic [TIME_W-1:0] now);
        int unsigned             win;
        int unsigned             oldest;
        logic signed [DUR_W-1:0] dur;
        logic signed [DUR_W-1:0] pred;
        t_frame_result           r;
        win = (win_reg == 0) ? 1 : (win_reg > RING_DEPTH) ? RING_DEPTH : win_reg;
        dur = tick_duration(now, prev_time);
        if (longint'(dur) > longint'(spike_reg)) begin
            dur = newest;
        end
        prev_time = now;
        while (fill >= win && fill > 0) begin
            oldest = (head + RING_DEPTH + 1 - fill) % RING_DEPTH;
            window_sum -= longint'(ring[oldest]);
            fill--;
        end
        head       = (head + 1) % RING_DEPTH;
        ring[head] = dur;
        newest     = dur;
        window_sum += longint'(dur);
        fill++;
        pred        = DUR_W'(window_sum / longint'(fill));
        elapsed_acc = elapsed_acc + TIME_W'(longint'(pred));
        frame_acc   = frame_acc + FRAME_W'(1);
        r.measured  = dur;
        r.predicted = pred;
        r.elapsed   = elapsed_acc;
        r.frames    = frame_acc;
        return r;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [CFG_DATA_W-1:0] noise_bits();
        return $urandom_range(1) ? rand_time() : '0;
    endfunction

    task automatic queue_at(input logic [TIME_W-1:0] t);
        t_cur = t;
        source_times = {source_times, t};
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_config(idx, data);
        t_cur = prev_time;
    endtask

    task automatic drain();
        while (source_times.size() != 0 || i_in_valid || expected_frames.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_frames = {expected_frames, smoother_step(i_source_time)};
            end
            if (!i_in_valid || !o_in_stall) begin
                if (source_times.size() != 0 && !take_break()) begin
                    i_in_valid    <= 1'b1;
                    i_source_time <= source_times[0];
                    source_times.delete(0);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= take_break();
    end

    // monitor
    always @(posedge i_clk) begin : monitor
        t_frame_result seen;
        t_frame_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.measured  = o_measured_duration;
            seen.predicted = o_predicted_duration;
            seen.elapsed   = o_elapsed_time;
            seen.frames    = o_frame_count;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected transaction: frame %0d", seen.frames);
                end
            end else begin
                want = expected_frames[0];
                expected_frames.delete(0);
                if (seen.measured !== want.measured || seen.predicted !== want.predicted ||
                    seen.elapsed !== want.elapsed || seen.frames !== want.frames) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("frame %0d: measured exp %0d got %0d, predicted exp %0d got %0d",
                                 want.frames, $signed(want.measured), $signed(seen.measured),
                                 $signed(want.predicted), $signed(seen.predicted));
                        $display("    elapsed exp %0d got %0d, count exp %0d got %0d",
                                 want.elapsed, seen.elapsed, want.frames, seen.frames);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_CYCLES) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : sequencer
        int unsigned           phase;
        int unsigned           n;
        int unsigned           frame_us;
        logic [CFG_DATA_W-1:0] cfg_word;

        win_reg     = WIN_RESET;
        def_reg     = DEF_RESET;
        spike_reg   = SPIKE_RESET;
        origin_reg  = '0;
        elapsed_acc = '0;
        frame_acc   = '0;
        clear_window();
        t_cur = prev_time;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: spike edge, saturation both ways, backward readings
        queue_at(48'd0);
        queue_at(48'd16667);
        queue_at(48'd33334);
        queue_at(t_cur + 48'd200000);
        queue_at(t_cur + 48'd200001);
        queue_at(TIME_MAX);
        queue_at(48'd0);
        queue_at(SAT_SPAN);
        queue_at(48'd0);
        queue_at(48'd5);
        queue_at(48'd3);
        for (n = 0; n < 6; n++) begin
            queue_at(t_cur + 48'd16667);
        end
        drain();

        // window of one, widest limit, origin at the top of the time range
        write_reg(CFG_ORIGIN + CFG_IDX_W'(2), rand_time());
        write_reg(CFG_WINDOW, 48'd1);
        write_reg(CFG_DEFAULT, 48'h3FFFF);
        write_reg(CFG_SPIKE, 48'h7FFF_FFFF);
        write_reg(CFG_ORIGIN, TIME_MAX);
        queue_at(TIME_MAX);
        queue_at(48'd0);
        queue_at(SAT_SPAN);
        queue_at(t_cur + 48'h8000_0000);
        queue_at(t_cur - 48'h8000_0000);
        drain();

        // zero window, zero limit, zero default
        write_reg(CFG_WINDOW, 48'd0);
        write_reg(CFG_DEFAULT, 48'd0);
        write_reg(CFG_SPIKE, 48'd0);
        write_reg(CFG_ORIGIN, 48'd0);
        queue_at(48'd0);
        queue_at(48'd1);
        queue_at(48'd0);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            calm = (phase == 3);

            cfg_word = noise_bits();
            case ($urandom_range(4))
                0:       cfg_word[WIN_W-1:0] = '0;
                1:       cfg_word[WIN_W-1:0] = WIN_W'(1);
                2:       cfg_word[WIN_W-1:0] = WIN_W'(RING_DEPTH);
                3:       cfg_word[WIN_W-1:0] = WIN_W'($urandom_range(127, RING_DEPTH + 1));
                default: cfg_word[WIN_W-1:0] = WIN_W'($urandom_range(RING_DEPTH - 1, 2));
            endcase
            write_reg(CFG_WINDOW, cfg_word);

            if ($urandom_range(3) == 0) begin
                write_reg(CFG_ORIGIN + CFG_IDX_W'($urandom_range(4, 1)), rand_time());
            end

            cfg_word = noise_bits();
            case ($urandom_range(3))
                0:       cfg_word[DEF_W-1:0] = '0;
                1:       cfg_word[DEF_W-1:0] = '1;
                default: cfg_word[DEF_W-1:0] = DEF_W'($urandom_range(200000));
            endcase
            write_reg(CFG_DEFAULT, cfg_word);

            cfg_word = noise_bits();
            case ($urandom_range(4))
                0:       cfg_word[SPIKE_W-1:0] = '0;
                1:       cfg_word[SPIKE_W-1:0] = '1;
                2:       cfg_word[SPIKE_W-1:0] = SPIKE_W'($urandom_range(1000));
                3:       cfg_word[SPIKE_W-1:0] = SPIKE_W'($urandom);
                default: cfg_word[SPIKE_W-1:0] = SPIKE_W'($urandom_range(400000, 10000));
            endcase
            write_reg(CFG_SPIKE, cfg_word);

            case ($urandom_range(2))
                0:       write_reg(CFG_ORIGIN, rand_time());
                1:       write_reg(CFG_ORIGIN, TIME_MAX - 48'($urandom_range(500000)));
                default: write_reg(CFG_ORIGIN, 48'($urandom_range(100000)));
            endcase

            frame_us = $urandom_range(50000, 4);
            for (n = 0; n < TICKS_PER_PHASE; n++) begin
                case ($urandom_range(99)) inside
                    [0:59]:  queue_at(t_cur + 48'(frame_us - frame_us / 4 +
                                                   $urandom_range(frame_us / 2)));
                    [60:69]: queue_at(t_cur + 48'(spike_reg) + 48'($urandom_range(5000, 1)));
                    [70:74]: queue_at(t_cur + 48'(spike_reg));
                    [75:84]: queue_at(t_cur - 48'($urandom_range(5000)));
                    [85:89]: queue_at(rand_time());
                    [90:94]: queue_at(t_cur + SAT_SPAN + 48'($urandom_range(2)) - 48'd1);
                    default: queue_at(t_cur - SAT_SPAN - 48'($urandom_range(2)));
                endcase
            end
        end

        drain();
        if (mismatches == 0 && expected_frames.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
